### rtl/core/cccc_pkg.sv
package cccc_pkg;

  localparam logic [7:0]        DUTY_MIN          = 8'd10;
  localparam logic [7:0]        DUTY_MAX          = 8'd254;
  localparam logic [9:0]        TICKS_PER_SECOND  = 10'd304;
  localparam logic [15:0]       PHASE_ONE_SECONDS = 16'd3000;
  localparam logic signed [7:0] REMOVED_TEMP      = -8'sd30;
  localparam logic [15:0]       SECONDS_MAX       = 16'hFFFF;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_CURRENT      = 4'd0,
    CFG_FUSE_CURRENT     = 4'd1,
    CFG_MIN_DUTY_LIMIT   = 4'd2,
    CFG_OPEN_LIMIT       = 4'd3,
    CFG_FULL_TEMPERATURE = 4'd4,
    CFG_CRIT_TEMPERATURE = 4'd5,
    CFG_STOP_VOLTAGE     = 4'd6,
    CFG_TIMEOUT_SECONDS  = 4'd7
  } cccc_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_CHARGING    = 3'd1,
    ST_FULL        = 3'd2,
    ST_OVERCURRENT = 3'd3,
    ST_OVERHEAT    = 3'd4,
    ST_BATT_FAIL   = 3'd5,
    ST_REMOVED     = 3'd6
  } cccc_status_t;

  typedef enum logic [1:0] {
    CAUSE_NONE        = 2'd0,
    CAUSE_TEMPERATURE = 2'd1,
    CAUSE_TIMEOUT     = 2'd2,
    CAUSE_VOLTAGE     = 2'd3
  } cccc_cause_t;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [9:0]        battery_current;
    logic [9:0]        battery_voltage;
    logic signed [7:0] temperature;
  } cccc_in_t;

  typedef struct packed {
    logic [7:0]   drive_level;
    cccc_status_t status;
    cccc_cause_t  full_cause;
    logic         voltage_checked;
  } cccc_out_t;

  typedef struct packed {
    logic [9:0]        set_current;
    logic [9:0]        fuse_current;
    logic [9:0]        min_duty_current_limit;
    logic [9:0]        open_current_limit;
    logic signed [7:0] full_temperature;
    logic signed [7:0] critical_temperature;
    logic [9:0]        stop_voltage;
    logic [14:0]       timeout_seconds;
  } cccc_cfg_t;

  typedef struct packed {
    logic        active;
    logic [7:0]  duty;
    logic [8:0]  tick_count;
    logic [15:0] elapsed_seconds;
    logic [15:0] last_seen_seconds;
  } cccc_state_t;

endpackage

### rtl/core/cccc_cfg.sv
module cccc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cccc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cccc_pkg::CFG_DATA_W-1:0] cfg_data,
  output cccc_pkg::cccc_cfg_t           cfg_o
);
  import cccc_pkg::*;

  cccc_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg_o     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_current            <= 10'd610;
      cfg_r.fuse_current           <= 10'd1022;
      cfg_r.min_duty_current_limit <= 10'd470;
      cfg_r.open_current_limit     <= 10'd50;
      cfg_r.full_temperature       <= 8'sd49;
      cfg_r.critical_temperature   <= 8'sd60;
      cfg_r.stop_voltage           <= 10'd900;
      cfg_r.timeout_seconds        <= 15'd3600;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SET_CURRENT:      cfg_r.set_current            <= cfg_data[9:0];
        CFG_FUSE_CURRENT:     cfg_r.fuse_current           <= cfg_data[9:0];
        CFG_MIN_DUTY_LIMIT:   cfg_r.min_duty_current_limit <= cfg_data[9:0];
        CFG_OPEN_LIMIT:       cfg_r.open_current_limit     <= cfg_data[9:0];
        CFG_FULL_TEMPERATURE: cfg_r.full_temperature       <= $signed(cfg_data[7:0]);
        CFG_CRIT_TEMPERATURE: cfg_r.critical_temperature   <= $signed(cfg_data[7:0]);
        CFG_STOP_VOLTAGE:     cfg_r.stop_voltage           <= cfg_data[9:0];
        CFG_TIMEOUT_SECONDS:  cfg_r.timeout_seconds        <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/cccc_step.sv
module cccc_step (
  input  cccc_pkg::cccc_cfg_t   cfg,
  input  cccc_pkg::cccc_state_t st,
  input  cccc_pkg::cccc_in_t    item,
  output cccc_pkg::cccc_state_t st_nxt,
  output cccc_pkg::cccc_out_t   res
);
  import cccc_pkg::*;

  logic       overcurrent;
  logic       batt_fail;
  logic       removed;
  logic       overheat;
  logic       full_temp;
  logic [7:0] duty_stepped;
  logic       timed_out;
  logic       volt_check;
  logic [9:0] tick_inc;
  logic       roll;
  logic [9:0] tick_wrap;

  assign overcurrent = (item.battery_current >= cfg.fuse_current) ||
                       ((st.duty == DUTY_MIN) &&
                        (item.battery_current > cfg.min_duty_current_limit));
  assign batt_fail   = (st.duty == DUTY_MAX) &&
                       (item.battery_current <= cfg.open_current_limit);
  assign removed     = item.temperature < REMOVED_TEMP;
  assign overheat    = item.temperature > cfg.critical_temperature;
  assign full_temp   = item.temperature > cfg.full_temperature;

  always_comb begin
    duty_stepped = st.duty;
    if (item.battery_current < cfg.set_current) begin
      if (st.duty < DUTY_MAX) duty_stepped = st.duty + 8'd1;
    end else if (item.battery_current > cfg.set_current) begin
      if (st.duty > DUTY_MIN) duty_stepped = st.duty - 8'd1;
    end
  end

  assign timed_out  = st.elapsed_seconds > {1'b0, cfg.timeout_seconds};
  assign volt_check = (st.last_seen_seconds != st.elapsed_seconds) &&
                      (st.elapsed_seconds > PHASE_ONE_SECONDS);
  assign tick_inc   = {1'b0, st.tick_count} + 10'd1;
  assign roll       = tick_inc > TICKS_PER_SECOND;
  assign tick_wrap  = roll ? (tick_inc - TICKS_PER_SECOND) : tick_inc;

  always_comb begin
    st_nxt = st;
    res.drive_level     = 8'd0;
    res.status          = ST_IDLE;
    res.full_cause      = CAUSE_NONE;
    res.voltage_checked = 1'b0;
    priority if (item.kind == KIND_START) begin
      st_nxt.active            = 1'b1;
      st_nxt.duty              = DUTY_MIN;
      st_nxt.tick_count        = 9'd0;
      st_nxt.elapsed_seconds   = 16'd0;
      st_nxt.last_seen_seconds = 16'd0;
      res.drive_level          = DUTY_MIN;
      res.status               = ST_CHARGING;
    end else if (!st.active) begin
      res.status = ST_IDLE;
    end else if (overcurrent) begin
      st_nxt.active = 1'b0;
      res.status    = ST_OVERCURRENT;
    end else if (batt_fail) begin
      st_nxt.active = 1'b0;
      res.status    = ST_BATT_FAIL;
    end else if (removed) begin
      st_nxt.active = 1'b0;
      res.status    = ST_REMOVED;
    end else if (overheat) begin
      st_nxt.active = 1'b0;
      res.status    = ST_OVERHEAT;
    end else if (full_temp) begin
      st_nxt.active  = 1'b0;
      res.status     = ST_FULL;
      res.full_cause = CAUSE_TEMPERATURE;
    end else begin
      st_nxt.duty = duty_stepped;
      priority if (timed_out) begin
        st_nxt.active  = 1'b0;
        res.status     = ST_FULL;
        res.full_cause = CAUSE_TIMEOUT;
      end else if (volt_check && (item.battery_voltage >= cfg.stop_voltage)) begin
        st_nxt.active            = 1'b0;
        st_nxt.last_seen_seconds = st.elapsed_seconds;
        res.status               = ST_FULL;
        res.full_cause           = CAUSE_VOLTAGE;
        res.voltage_checked      = 1'b1;
      end else begin
        st_nxt.last_seen_seconds = st.elapsed_seconds;
        st_nxt.tick_count        = tick_wrap[8:0];
        if (roll && (st.elapsed_seconds != SECONDS_MAX))
          st_nxt.elapsed_seconds = st.elapsed_seconds + 16'd1;
        res.drive_level     = duty_stepped;
        res.status          = ST_CHARGING;
        res.voltage_checked = volt_check;
      end
    end
  end

endmodule

### rtl/core/constant_current_charge_controller.sv
// Constant-current fast-charge session controller. A start transfer opens a
// session at minimum duty; each sample transfer (current, voltage, temperature)
// yields one result with the drive level, status and cause of any stop. One
// item per clock: an input register feeds a single pass of compare and
// duty-step logic into the result register, and the session state updates
// as the item moves across, so throughput is one item per cycle while
// out_ready stays high. Configuration writes are taken every cycle and
// apply from the next item; write them only while no item is in flight.
module constant_current_charge_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  cccc_pkg::cccc_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output cccc_pkg::cccc_out_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cccc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cccc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cccc_pkg::*;

  cccc_cfg_t   cfg;
  cccc_in_t    in_data_r;
  logic        in_vld_r;
  cccc_out_t   out_data_r;
  logic        out_vld_r;
  cccc_state_t st_r;
  cccc_state_t st_nxt;
  cccc_out_t   res;
  logic        adv;

  cccc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  cccc_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (in_data_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_data_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      st_r      <= '0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
      st_r      <= st_nxt;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= res;
  end

  // drive only while charging
  a_drive_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_data_r.status != ST_CHARGING) |-> out_data_r.drive_level == 8'd0)
    else $error("drive level non-zero outside charging");

  a_cause_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (out_data_r.full_cause != CAUSE_NONE) |-> out_data_r.status == ST_FULL)
    else $error("full cause without full status");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.active |-> (st_r.duty >= DUTY_MIN) && (st_r.duty <= DUTY_MAX))
    else $error("duty outside range during session");

  a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, st_r.tick_count} <= TICKS_PER_SECOND)
    else $error("tick count beyond one second");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(st_r))
    else $error("session state moved without a transfer");

endmodule

### bench/tb_constant_current_charge_controller.sv
module tb_constant_current_charge_controller;
  import cccc_pkg::*;

  localparam int STALL_LIMIT    = 500;

  typedef struct {
    cccc_in_t    item;
    int unsigned gap;
  } feed_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  cccc_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  cccc_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  feed_t       sample_feed[$];
  cccc_out_t   due_results[$];
  logic        in_taken   = 1'b0;
  logic        out_taken  = 1'b0;
  int unsigned lead       = 0;
  int          stall_left = 0;
  int          quiet_left = 0;
  int          idle_cycles = 0;
  int          errors     = 0;
  int          items_in   = 0;
  int          results_seen = 0;
  int          reg_writes = 0;
  int          volt_checks = 0;
  int          outcome[0:7];

  // shadow of the block's registers and session state
  cccc_cfg_t   limits = '{10'd610, 10'd1022, 10'd470, 10'd50, 8'sd49, 8'sd60, 10'd900, 15'd3600};
  logic        in_session = 1'b0;
  logic [7:0]  duty_lvl   = '0;
  logic [8:0]  tick_cnt   = '0;
  logic [15:0] secs       = '0;
  logic [15:0] seen_secs  = '0;

  constant_current_charge_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic cccc_out_t charge_step(cccc_in_t it);
    cccc_out_t  r;
    logic [9:0] t;
    r.drive_level     = '0;
    r.status          = ST_IDLE;
    r.full_cause      = CAUSE_NONE;
    r.voltage_checked = 1'b0;
    if (it.kind == KIND_START) begin
      in_session    = 1'b1;
      duty_lvl      = DUTY_MIN;
      tick_cnt      = '0;
      secs          = '0;
      seen_secs     = '0;
      r.drive_level = DUTY_MIN;
      r.status      = ST_CHARGING;
    end else if (in_session) begin
      if (it.battery_current >= limits.fuse_current ||
          (duty_lvl == DUTY_MIN && it.battery_current > limits.min_duty_current_limit)) begin
        r.status = ST_OVERCURRENT;
      end else if (duty_lvl == DUTY_MAX && it.battery_current <= limits.open_current_limit) begin
        r.status = ST_BATT_FAIL;
      end else if ($signed(it.temperature) < REMOVED_TEMP) begin
        r.status = ST_REMOVED;
      end else if ($signed(it.temperature) > $signed(limits.critical_temperature)) begin
        r.status = ST_OVERHEAT;
      end else if ($signed(it.temperature) > $signed(limits.full_temperature)) begin
        r.status     = ST_FULL;
        r.full_cause = CAUSE_TEMPERATURE;
      end else begin
        if (it.battery_current < limits.set_current) begin
          if (duty_lvl < DUTY_MAX) duty_lvl++;
        end else if (it.battery_current > limits.set_current) begin
          if (duty_lvl > DUTY_MIN) duty_lvl--;
        end
        if (secs > {1'b0, limits.timeout_seconds}) begin
          r.status     = ST_FULL;
          r.full_cause = CAUSE_TIMEOUT;
        end else begin
          if (seen_secs != secs) begin
            seen_secs = secs;
            if (secs > PHASE_ONE_SECONDS) begin
              r.voltage_checked = 1'b1;
              if (it.battery_voltage >= limits.stop_voltage) begin
                r.status     = ST_FULL;
                r.full_cause = CAUSE_VOLTAGE;
              end
            end
          end
          if (r.status == ST_IDLE) begin
            t = {1'b0, tick_cnt} + 10'd1;
            if (t > TICKS_PER_SECOND) begin
              t = t - TICKS_PER_SECOND;
              if (secs != SECONDS_MAX) secs++;
            end
            tick_cnt      = t[8:0];
            r.drive_level = duty_lvl;
            r.status      = ST_CHARGING;
          end
        end
      end
      if (r.status != ST_CHARGING) in_session = 1'b0;
    end
    outcome[r.status]++;
    if (r.voltage_checked) volt_checks++;
    return r;
  endfunction

  task automatic mismatch(string field, logic [7:0] want_v, logic [7:0] got_v);
    errors++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
  endtask

  // input side: present items, honouring each item's lead-in gap
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (sample_feed.size() == 0) begin
        in_valid <= 1'b0;
      end else if (lead < sample_feed[0].gap) begin
        lead++;
        in_valid <= 1'b0;
      end else begin
        lead = 0;
        in_data  <= sample_feed[0].item;
        in_valid <= 1'b1;
        void'(sample_feed.pop_front());
      end
    end
  end

  // result side back-pressure, with occasional quiet stretches
  always @(negedge clk) begin : sink_pace
    int hold;
    hold = stall_left;
    if (out_taken) begin
      if (quiet_left != 0) hold = 0;
      else hold = $urandom_range(0, 12);
      if (quiet_left != 0) quiet_left--;
      else if ($urandom_range(0, 31) == 0) quiet_left = 40;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (hold == 0) begin
      out_ready <= 1'b1;
      stall_left = 0;
    end else begin
      out_ready <= 1'b0;
      stall_left = hold - 1;
    end
  end

  always @(posedge clk) begin : observe
    cccc_out_t want;
    in_taken  <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back(charge_step(in_data));
        items_in++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %p", $time, out_data);
        end else begin
          want = due_results.pop_front();
          if (out_data.drive_level !== want.drive_level)
            mismatch("drive_level", want.drive_level, out_data.drive_level);
          if (out_data.status !== want.status)
            mismatch("status", 8'(want.status), 8'(out_data.status));
          if (out_data.full_cause !== want.full_cause)
            mismatch("full_cause", 8'(want.full_cause), 8'(out_data.full_cause));
          if (out_data.voltage_checked !== want.voltage_checked)
            mismatch("voltage_checked", 8'(want.voltage_checked),
                     8'(out_data.voltage_checked));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void feed(cccc_in_t item, bit calm);
    feed_t f;
    f.item = item;
    f.gap  = calm ? 0 : $urandom_range(0, 12);
    sample_feed.push_back(f);
  endfunction

  function automatic cccc_in_t noise_item();
    logic [31:0] r;
    r = $urandom;
    return r[$bits(cccc_in_t)-1:0];
  endfunction

  function automatic cccc_in_t start_item();
    cccc_in_t it;
    it      = noise_item();
    it.kind = KIND_START;
    return it;
  endfunction

  function automatic cccc_in_t sample(logic [9:0] cur, logic [9:0] volt,
                                      logic signed [7:0] temp);
    cccc_in_t it;
    it.kind            = KIND_SAMPLE;
    it.battery_current = cur;
    it.battery_voltage = volt;
    it.temperature     = temp;
    return it;
  endfunction

  // current that keeps a session alive; rising keeps it under target
  function automatic logic [9:0] safe_current(bit rising);
    int lo, hi, pick;
    hi = int'(limits.fuse_current) - 1;
    if (hi > int'(limits.min_duty_current_limit)) hi = int'(limits.min_duty_current_limit);
    if (rising && hi >= int'(limits.set_current)) hi = int'(limits.set_current) - 1;
    if (hi < 0) hi = 0;
    lo = int'(limits.open_current_limit) + 1;
    if (lo > hi) lo = hi;
    if (!rising && $urandom_range(0, 1) == 1) begin
      pick = int'(limits.set_current) + int'($urandom_range(0, 8)) - 4;
      if (pick < lo) pick = lo;
      if (pick > hi) pick = hi;
    end else begin
      pick = int'($urandom_range(hi, lo));
    end
    return pick[9:0];
  endfunction

  function automatic logic signed [7:0] safe_temp();
    int lo, hi, pick;
    lo = REMOVED_TEMP;
    hi = limits.full_temperature;
    if (int'(limits.critical_temperature) < hi) hi = limits.critical_temperature;
    if (hi < lo) hi = lo;
    pick = lo + int'($urandom_range(hi - lo, 0));
    return pick[7:0];
  endfunction

  task automatic gen_session(int n, bit rising);
    bit       calm;
    cccc_in_t tail;
    calm = ($urandom_range(0, 3) == 0);
    feed(start_item(), calm);
    repeat (n) feed(sample(safe_current(rising), 10'($urandom), safe_temp()), calm);
    if (rising) begin
      feed(sample(10'($urandom_range(limits.open_current_limit, 0)), 10'($urandom),
                  safe_temp()), calm);
    end else if ($urandom_range(0, 1) == 1) begin
      tail      = noise_item();
      tail.kind = KIND_SAMPLE;
      feed(tail, calm);
    end
  endtask

  task automatic mixed_traffic(int budget);
    int sent, n;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) feed(noise_item(), 1'b0);
      end else begin
        n = $urandom_range(1, 24);
        gen_session(n, 1'b0);
      end
      sent += n + 1;
    end
  endtask

  task automatic settle();
    while (sample_feed.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      CFG_SET_CURRENT:      limits.set_current            = val[9:0];
      CFG_FUSE_CURRENT:     limits.fuse_current           = val[9:0];
      CFG_MIN_DUTY_LIMIT:   limits.min_duty_current_limit = val[9:0];
      CFG_OPEN_LIMIT:       limits.open_current_limit     = val[9:0];
      CFG_FULL_TEMPERATURE: limits.full_temperature       = val[7:0];
      CFG_CRIT_TEMPERATURE: limits.critical_temperature   = val[7:0];
      CFG_STOP_VOLTAGE:     limits.stop_voltage           = val[9:0];
      CFG_TIMEOUT_SECONDS:  limits.timeout_seconds        = val;
      default: ;
    endcase
  endtask

  task automatic apply_limits(cccc_cfg_t c);
    write_reg(CFG_SET_CURRENT,      {5'($urandom), c.set_current});
    write_reg(CFG_FUSE_CURRENT,     {5'($urandom), c.fuse_current});
    write_reg(CFG_MIN_DUTY_LIMIT,   {5'($urandom), c.min_duty_current_limit});
    write_reg(CFG_OPEN_LIMIT,       {5'($urandom), c.open_current_limit});
    write_reg(CFG_FULL_TEMPERATURE, {7'($urandom), c.full_temperature});
    write_reg(CFG_CRIT_TEMPERATURE, {7'($urandom), c.critical_temperature});
    write_reg(CFG_STOP_VOLTAGE,     {5'($urandom), c.stop_voltage});
    write_reg(CFG_TIMEOUT_SECONDS,  c.timeout_seconds);
    // unmapped index must leave everything alone
    write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, int'(CFG_TIMEOUT_SECONDS) + 1)),
              CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : script
    cccc_cfg_t   c;
    logic [95:0] r96;
    foreach (outcome[k]) outcome[k] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset register values, field extremes, overcurrent, removal, overheat and full-temperature stops
    feed(sample(10'h3FF, 10'h3FF, 8'sd127), 1'b0);
    feed(sample(10'd0, 10'd0, -8'sd128), 1'b0);
    feed('{KIND_START, 10'h3FF, 10'h3FF, -8'sd1}, 1'b0);
    feed(sample(10'h3FF, 10'd0, 8'sd20), 1'b0);
    feed('{KIND_START, 10'd0, 10'd0, 8'sd0}, 1'b0);
    feed(sample(10'd471, 10'd500, 8'sd20), 1'b0);
    feed(start_item(), 1'b0);
    feed(sample(10'd470, 10'd0, -8'sd30), 1'b0);
    feed(sample(10'd610, 10'h3FF, 8'sd49), 1'b0);
    feed(sample(10'd611, 10'd512, 8'sd0), 1'b0);
    feed(sample(10'd1022, 10'd0, 8'sd0), 1'b0);
    feed(start_item(), 1'b0);
    feed(sample(10'd0, 10'd0, -8'sd31), 1'b0);
    feed(start_item(), 1'b0);
    feed(sample(10'd100, 10'd0, 8'sd61), 1'b0);
    feed(start_item(), 1'b0);
    feed(sample(10'd100, 10'd0, 8'sd50), 1'b0);
    feed(start_item(), 1'b0);
    feed(start_item(), 1'b0);
    feed(sample(10'd300, 10'd700, 8'sd127), 1'b0);
    feed(start_item(), 1'b0);
    feed(sample(10'd0, 10'h3FF, -8'sd128), 1'b0);
    settle();

    c = '{10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'sd127, 8'sd127, 10'd0, 15'd0};
    apply_limits(c);
    mixed_traffic(80);
    settle();

    c = '{10'd0, 10'd0, 10'd0, 10'd0, -8'sd128, -8'sd128, 10'd1023, 15'd0};
    apply_limits(c);
    mixed_traffic(60);
    settle();

    // zero timeout: session ends as full after the first second
    c = '{10'd512, 10'd1000, 10'd600, 10'd20, 8'sd40, 8'sd55, 10'd900, 15'd0};
    apply_limits(c);
    gen_session(320, 1'b0);
    mixed_traffic(60);
    settle();

    // duty ramps to full, then an open battery
    c = '{10'd610, 10'd1022, 10'd470, 10'd50, 8'sd49, 8'sd60, 10'd900, 15'd3600};
    apply_limits(c);
    gen_session(250, 1'b1);
    mixed_traffic(80);
    settle();

    repeat (2) begin
      r96 = {$urandom, $urandom, $urandom};
      c   = r96[$bits(cccc_cfg_t)-1:0];
      apply_limits(c);
      mixed_traffic(100);
      settle();
    end

    $display("Sent %0d items, compared %0d results, made %0d register writes.",
             items_in, results_seen, reg_writes);
    $display("Outcomes: idle %0d, charging %0d, full %0d, overcurrent %0d, overheat %0d,",
             outcome[ST_IDLE], outcome[ST_CHARGING], outcome[ST_FULL],
             outcome[ST_OVERCURRENT], outcome[ST_OVERHEAT]);
    $display("  failure %0d, removed %0d, voltage compares %0d, mismatches %0d.",
             outcome[ST_BATT_FAIL], outcome[ST_REMOVED], volt_checks, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/cccc_pkg.sv
rtl/core/cccc_cfg.sv
rtl/core/cccc_step.sv
rtl/core/constant_current_charge_controller.sv
bench/tb_constant_current_charge_controller.sv
